/* rtl/utf8d_pkg.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the UTF-8 stream decoder.
// -----------------------------------------------------------------------------
package utf8d_pkg;

	// code point width
	localparam int CP_W = 21;

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int CNT_W      = 3;

	// input kinds
	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	// replacement character
	localparam logic [CP_W-1:0] ERR_CP_RESET = 21'h00FFFD;

	// byte class bounds
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] CONT_MIN  = 8'h80;
	localparam logic [7:0] CONT_MAX  = 8'hBF;
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD2_MAX = 8'hDF;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD3_MAX = 8'hEF;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD4_MAX = 8'hF7;

	// one result beat
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            is_error;
		logic            last_of_run;
	} result_t;

	// results produced by one byte, in order
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} decode_out_t;

endpackage
`default_nettype wire

/* rtl/utf8d_byte_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// utf8d_byte_if
// Valid/ready channel carrying one input byte or an end-of-stream flush.
// -----------------------------------------------------------------------------
interface utf8d_byte_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] byte_value;

	modport source (output valid, output kind, output byte_value, input ready);
	modport sink   (input valid, input kind, input byte_value, output ready);
endinterface
`default_nettype wire

/* rtl/utf8d_cp_if.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// utf8d_cp_if
// Valid/ready channel carrying one decoded code point result.
// -----------------------------------------------------------------------------
interface utf8d_cp_if;
	logic                       valid;
	logic                       ready;
	logic [utf8d_pkg::CP_W-1:0] code_point;
	logic                       is_error;
	logic                       last_of_run;

	modport source (output valid, output code_point, output is_error,
		output last_of_run, input ready);
	modport sink   (input valid, input code_point, input is_error,
		input last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/utf8d_decode.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// utf8d_decode
// Sequence state, error code point register and per-byte decode logic.
// -----------------------------------------------------------------------------
module utf8d_decode (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [utf8d_pkg::CP_W-1:0] cfg_wdata,
	input  wire logic                       fire,
	input  wire logic                       kind,
	input  wire logic [7:0]                 byte_value,
	output utf8d_pkg::decode_out_t          res
);

	logic [utf8d_pkg::CP_W-1:0] err_cp_q;
	logic [utf8d_pkg::CP_W-1:0] acc_q;
	logic [1:0]                 rem_q;
	logic [utf8d_pkg::CP_W-1:0] acc_d;
	logic [1:0]                 rem_d;
	logic [utf8d_pkg::CP_W-1:0] acc_shift;
	logic                       pend;

	assign pend      = (rem_q != 2'd0);
	assign acc_shift = {acc_q[utf8d_pkg::CP_W-7:0], byte_value[5:0]};

	// error code point register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_cp_q <= utf8d_pkg::ERR_CP_RESET;
		end else if (cfg_we) begin
			err_cp_q <= cfg_wdata;
		end
	end

	// decode: results and next state
	always_comb begin
		acc_d          = acc_q;
		rem_d          = rem_q;
		res.cnt        = 2'd0;
		res.r0         = '{code_point: err_cp_q, is_error: 1'b1, last_of_run: 1'b1};
		res.r1         = '{code_point: {13'd0, byte_value}, is_error: 1'b0,
			last_of_run: 1'b1};
		if (kind == utf8d_pkg::KIND_FLUSH) begin
			// end of stream: flag an unfinished sequence
			res.cnt = pend ? 2'd1 : 2'd0;
			acc_d   = '0;
			rem_d   = 2'd0;
		end else if (byte_value inside {[8'h00:utf8d_pkg::ASCII_MAX]}) begin
			rem_d = 2'd0;
			if (pend) begin
				res.cnt            = 2'd2;
				res.r0.last_of_run = 1'b0;
			end else begin
				res.cnt = 2'd1;
				res.r0  = res.r1;
			end
		end else if (byte_value inside {[utf8d_pkg::CONT_MIN:utf8d_pkg::CONT_MAX]}) begin
			if (pend) begin
				acc_d = acc_shift;
				rem_d = rem_q - 2'd1;
				if (rem_q == 2'd1) begin
					res.cnt = 2'd1;
					res.r0  = '{code_point: acc_shift, is_error: 1'b0, last_of_run: 1'b1};
				end
			end else begin
				// stray continuation
				res.cnt = 2'd1;
			end
		end else if (byte_value inside {[utf8d_pkg::LEAD2_MIN:utf8d_pkg::LEAD2_MAX]}) begin
			acc_d = {16'd0, byte_value[4:0]};
			rem_d = 2'd1;
		end else if (byte_value inside {[utf8d_pkg::LEAD3_MIN:utf8d_pkg::LEAD3_MAX]}) begin
			acc_d = {17'd0, byte_value[3:0]};
			rem_d = 2'd2;
		end else if (byte_value inside {[utf8d_pkg::LEAD4_MIN:utf8d_pkg::LEAD4_MAX]}) begin
			acc_d = {18'd0, byte_value[2:0]};
			rem_d = 2'd3;
		end else begin
			// invalid byte
			res.cnt = 2'd1;
			rem_d   = 2'd0;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			rem_q <= 2'd0;
		end else if (fire) begin
			acc_q <= acc_d;
			rem_q <= rem_d;
		end
	end

	// two results: error first, then the plain byte
	a_two_order: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.cnt == 2'd2) |-> (res.r0.is_error && !res.r0.last_of_run
			&& !res.r1.is_error && res.r1.last_of_run))
		else $error("two-result order wrong");

	// a single result always closes the run
	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.cnt == 2'd1) |-> res.r0.last_of_run)
		else $error("single result not marked last");

	// flush leaves an empty state
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && kind == utf8d_pkg::KIND_FLUSH) |=> (rem_q == 2'd0 && acc_q == '0))
		else $error("flush did not clear state");

endmodule
`default_nettype wire

/* rtl/utf8d_result_fifo.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// utf8d_result_fifo
// Four-entry result queue taking up to two beats a cycle while it has room, giving one while the reader is ready.
// -----------------------------------------------------------------------------
module utf8d_result_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire utf8d_pkg::decode_out_t push,
	output logic                        room,
	utf8d_cp_if.source                  cp_out
);

	utf8d_pkg::result_t              mem_q [utf8d_pkg::FIFO_DEPTH];
	logic [utf8d_pkg::FIFO_AW-1:0]   head_q;
	logic [utf8d_pkg::FIFO_AW-1:0]   tail_q;
	logic [utf8d_pkg::CNT_W-1:0]     count_q;
	logic [utf8d_pkg::CNT_W-1:0]     after_pop;
	logic                            pop;
	utf8d_pkg::result_t              head_ent;

	assign pop       = cp_out.valid && cp_out.ready;
	assign after_pop = count_q - {{(utf8d_pkg::CNT_W-1){1'b0}}, pop};
	// two free slots once this cycle's pop is counted
	assign room      = (after_pop <= utf8d_pkg::CNT_W'(utf8d_pkg::FIFO_DEPTH - 2));

	// head beat to the port
	assign head_ent           = mem_q[head_q];
	assign cp_out.valid       = (count_q != '0);
	assign cp_out.code_point  = head_ent.code_point;
	assign cp_out.is_error    = head_ent.is_error;
	assign cp_out.last_of_run = head_ent.last_of_run;

	// storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[tail_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[tail_q + utf8d_pkg::FIFO_AW'(1)] <= push.r1;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + utf8d_pkg::FIFO_AW'(push.cnt);
			head_q  <= head_q + utf8d_pkg::FIFO_AW'(pop);
			count_q <= after_pop + utf8d_pkg::CNT_W'(push.cnt);
		end
	end

	// fill never exceeds the depth
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= utf8d_pkg::CNT_W'(utf8d_pkg::FIFO_DEPTH))
		else $error("result queue overfilled");

	// writes only land with free slots
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("push without room");

	// a stalled head beat holds
	a_head_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cp_out.valid && !cp_out.ready) |=> (cp_out.valid
			&& cp_out.code_point == $past(cp_out.code_point)
			&& cp_out.last_of_run == $past(cp_out.last_of_run)))
		else $error("head beat changed while stalled");

endmodule
`default_nettype wire

/* rtl/utf8_stream_decoder.sv */
`default_nettype none
// -----------------------------------------------------------------------------
// utf8_stream_decoder
// UTF-8 byte stream to code point decoder with a configurable error value.
// -----------------------------------------------------------------------------
//  channel    dir   beat                                   handshake
//  byte_in    in    kind, byte_value                       valid/ready
//  cp_out     out   code_point, is_error, last_of_run      valid/ready
//  cfg        in    cfg_wdata (error code point)           cfg_we, no wait
//
//  One byte accepted per cycle while the queue has room; a result passes the
//  input register, then decode into the result queue, before it leaves.
//  A byte making two results needs two output beats, so the rate
//  is set by the one-beat-per-cycle output port of the result queue.
//  byte_in.ready drops when a byte is held and the queue lacks two free slots.
//  Reset clears the sequence state, the queue and restores U+FFFD.
// -----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [utf8d_pkg::CP_W-1:0] cfg_wdata,
	utf8d_byte_if.sink                      byte_in,
	utf8d_cp_if.source                      cp_out
);

	logic                   valid_s1;
	logic                   kind_s1;
	logic [7:0]             byte_s1;
	logic                   room;
	logic                   fire;
	utf8d_pkg::decode_out_t res;
	utf8d_pkg::decode_out_t push;

	// decode the held byte when the queue can take its results
	assign fire          = valid_s1 && room;
	assign byte_in.ready = !valid_s1 || fire;
	assign push          = fire ? res : '{cnt: 2'd0, r0: res.r0, r1: res.r1};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			kind_s1 <= byte_in.kind;
			byte_s1 <= byte_in.byte_value;
		end
	end

	utf8d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fire       (fire),
		.kind       (kind_s1),
		.byte_value (byte_s1),
		.res        (res)
	);

	utf8d_result_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.cp_out (cp_out)
	);

endmodule
`default_nettype wire
